// ----- hdl/modbus_rtu_master_transaction_macros.svh -----
// assertion macros for the modbus rtu master
// used by the modules that assert; no other dependencies
`ifndef MODBUS_RTU_MASTER_TRANSACTION_MACROS_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_MACROS_SVH
`ifndef SYNTHESIS
`define MRM_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define MRM_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define MRM_ASSERT_IMP(label, clk, rst, a, c)
`define MRM_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ----- hdl/mbrtu_pkg.sv -----
// shared types and constants for the modbus rtu master
// no dependencies
`timescale 1ns / 1ps
package mbrtu_pkg;
  localparam int TxFrameBytes = 32;
  localparam int RxFrameBytes = 64;
  localparam int MaxReadRegs = 16;
  localparam int PayloadDepth = 32;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  localparam logic [1:0] RES_TX = 2'd0;
  localparam logic [1:0] RES_DATA = 2'd1;
  localparam logic [1:0] RES_STATUS = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_CRC = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_BUSY = 3'd4;
  localparam logic [2:0] ST_INVALID = 3'd5;

  localparam logic [7:0] FN_READ_HOLD = 8'd3;
  localparam logic [7:0] FN_READ_INPUT = 8'd4;
  localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FN_WRITE_MULTI = 8'd16;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] slave_id;
    logic [7:0] function_code;
    logic [15:0] register_address;
    logic [6:0] register_count;
    logic [4:0] payload_index;
    logic [7:0] data_byte;
    logic [15:0] timeout_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] byte_value;
    logic [2:0] status;
    logic last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TX_BYTE, S_TX_CRC, S_TX_EMIT, S_RX_CRC, S_RX_RD0, S_RX_RD1,
    S_FIN, S_DATA_RD, S_DATA_EMIT, S_STATUS
  } state_t;

  // shared crc unit control
  typedef struct packed {
    logic load;
    logic [15:0] init;
    logic [7:0] data;
  } crc_ctl_t;
endpackage

// ----- hdl/mbrtu_if.sv -----
// valid/ready channel carrying one item
// depends on mbrtu_pkg
`timescale 1ns / 1ps
interface mbrtu_in_if;
  import mbrtu_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mbrtu_out_if;
  import mbrtu_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/mbrtu_crc.sv -----
// bit-serial crc-16 unit, one polynomial step a cycle
// depends on mbrtu_pkg and the assertion macros
`timescale 1ns / 1ps
`include "modbus_rtu_master_transaction_macros.svh"
module mbrtu_crc (
  input logic clk,
  input logic rst,
  input mbrtu_pkg::crc_ctl_t ctl,
  output logic [15:0] crc,
  output logic done
);
  import mbrtu_pkg::*;
  logic [3:0] cnt;
  logic [15:0] crc_next;

  always_comb begin
    crc_next = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 4'd8;
      crc <= CrcInit;
    end else if (ctl.load) begin
      crc <= ctl.init ^ {8'd0, ctl.data};
      cnt <= 4'd0;
    end else if (cnt != 4'd8) begin
      crc <= crc_next;
      cnt <= cnt + 4'd1;
    end
  end

  assign done = (cnt == 4'd8) && !ctl.load;

  `MRM_ASSERT_NEXT(a_crc_start, clk, rst, ctl.load, !done)
  `MRM_ASSERT_IMP(a_crc_cnt, clk, rst, 1'b1, cnt <= 4'd8)
  `MRM_ASSERT_NEXT(a_crc_hold, clk, rst, done && !ctl.load, crc == $past(crc))
endmodule

// ----- hdl/modbus_rtu_master_transaction.sv -----
// The shared bit-serial CRC unit sets the pace: every frame byte and every received
// byte is folded through it before the block moves on. A completion reads back the
// id and function, then hands out the data bytes and a status; a rejected start gives a status.
// Output stalls hold every result. The block takes one item at a time and is ready
// again once its last result sits in the output register.
// Synchronous active-high reset clears control state; stores are not cleared.
`timescale 1ns / 1ps
`include "modbus_rtu_master_transaction_macros.svh"
module modbus_rtu_master_transaction (
  input logic clk,
  input logic rst,
  mbrtu_in_if.sink in_ch,
  mbrtu_out_if.source out_ch
);
  import mbrtu_pkg::*;

  state_t state, state_next;
  in_item_t req;
  logic busy_flag;
  logic [7:0] pending_id, pending_function;
  logic [6:0] pending_registers;
  logic [7:0] expected_length, received_count;
  logic [15:0] running_crc, elapsed_ms, timeout_limit;
  logic [7:0] payload_store [PayloadDepth];
  logic [7:0] receive_store [RxFrameBytes];
  logic [7:0] pl_rd, rx_rd;
  logic [4:0] pl_addr;
  logic [5:0] rx_addr;
  logic [7:0] tx_pos, tx_len, tx_byte, tx_rd_pos;
  logic [15:0] tx_crc;
  logic [7:0] rx0, rx1, n_data, d_pos;
  logic [7:0] rd_cap, n_first, n_cur;
  logic [2:0] st_code;
  logic ov_valid, ov_set;
  out_item_t ov;
  crc_ctl_t cctl;
  logic [15:0] crc_q;
  logic crc_done;
  logic accept, out_free;
  logic req_ok;
  logic [7:0] exp_len, frm_len;
  logic is_read;
  logic start_busy;

  mbrtu_crc u_crc (.clk(clk), .rst(rst), .ctl(cctl), .crc(crc_q), .done(crc_done));

  assign accept = in_ch.valid && in_ch.ready;
  assign out_free = !ov_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = ov_valid;
  assign out_ch.data = ov;
  assign is_read = (req.function_code == FN_READ_HOLD) ||
                   (req.function_code == FN_READ_INPUT);
  // payload read runs one position ahead while a byte is being handed out
  assign tx_rd_pos = (state == S_TX_EMIT) ? tx_pos + 8'd1 : tx_pos;

  // request check and lengths
  always_comb begin
    req_ok = 1'b0;
    exp_len = 8'd8;
    frm_len = 8'd6;
    if (is_read) begin
      req_ok = (req.register_count != 7'd0) && (req.register_count <= 7'(MaxReadRegs)) &&
               (9'd5 + {1'b0, req.register_count, 1'b0} <= 9'(RxFrameBytes));
      exp_len = 8'd5 + {req.register_count, 1'b0};
    end else if (req.function_code == FN_WRITE_SINGLE) begin
      req_ok = 1'b1;
    end else if (req.function_code == FN_WRITE_MULTI) begin
      req_ok = (req.register_count != 7'd0) &&
               ({1'b0, req.register_count, 1'b0} <= 9'(PayloadDepth)) &&
               (9'd9 + {1'b0, req.register_count, 1'b0} <= 9'(TxFrameBytes));
      frm_len = 8'd7 + {req.register_count, 1'b0};
    end
  end

  // frame byte at tx_pos (payload bytes come from pl_rd)
  always_comb begin
    unique case (tx_pos)
      8'd0: tx_byte = req.slave_id;
      8'd1: tx_byte = req.function_code;
      8'd2: tx_byte = req.register_address[15:8];
      8'd3: tx_byte = req.register_address[7:0];
      8'd4: tx_byte = (req.function_code == FN_WRITE_SINGLE) ? pl_rd : 8'd0;
      8'd5: tx_byte = (req.function_code == FN_WRITE_SINGLE) ? pl_rd
                                                             : {1'b0, req.register_count};
      8'd6: tx_byte = {req.register_count, 1'b0};
      default: tx_byte = pl_rd;
    endcase
  end

  always_comb begin
    if (tx_rd_pos == 8'd4) pl_addr = 5'd0;
    else if (tx_rd_pos == 8'd5) pl_addr = 5'd1;
    else pl_addr = 5'(tx_rd_pos - 8'd7);
    if (state == S_RX_RD0 || state == S_IDLE) rx_addr = 6'd0;
    else if (state == S_RX_RD1) rx_addr = 6'd1;
    else if (state == S_FIN) rx_addr = 6'd2;
    else rx_addr = 6'(d_pos + 8'd3);
  end

  // data byte count; on the first data visit rx_rd holds the byte count field
  always_comb begin
    rd_cap = {pending_registers, 1'b0};
    n_first = 8'd0;
    if (pending_function == FN_READ_HOLD || pending_function == FN_READ_INPUT)
      n_first = (rx_rd > rd_cap) ? rd_cap : rx_rd;
    n_cur = (d_pos == 8'd0) ? n_first : n_data;
  end

  always_ff @(posedge clk) begin
    pl_rd <= payload_store[pl_addr];
    rx_rd <= receive_store[rx_addr];
    if (accept && in_ch.data.kind == KIND_LOAD)
      payload_store[in_ch.data.payload_index] <= in_ch.data.data_byte;
    if (accept && in_ch.data.kind == KIND_LINE && busy_flag &&
        received_count < 8'(RxFrameBytes))
      receive_store[6'(received_count)] <= in_ch.data.data_byte;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) begin
        unique case (in_ch.data.kind)
          KIND_LOAD: state_next = S_IDLE;
          KIND_START: state_next = S_TX_BYTE;
          KIND_LINE: state_next = busy_flag ? S_RX_CRC : S_IDLE;
          default: state_next = busy_flag ? S_STATUS : S_IDLE;
        endcase
      end
      S_TX_BYTE: if (start_busy || !req_ok) state_next = S_STATUS;
        else state_next = S_TX_CRC;
      S_TX_CRC: if (crc_done && out_free) state_next = S_TX_EMIT;
      S_TX_EMIT: if (out_free) begin
        if (tx_pos + 8'd1 == tx_len + 8'd2) state_next = S_IDLE;
        else state_next = S_TX_BYTE;
      end
      S_RX_CRC: if (crc_done) begin
        if (received_count >= expected_length || received_count >= 8'(RxFrameBytes))
          state_next = S_RX_RD0;
        else state_next = S_IDLE;
      end
      S_RX_RD0: state_next = S_RX_RD1;
      S_RX_RD1: state_next = S_FIN;
      S_FIN: state_next = S_DATA_RD;
      S_DATA_RD: state_next = (d_pos < n_cur && d_pos + 8'd3 < 8'(RxFrameBytes) &&
                               rx0 == pending_id && rx1 == pending_function &&
                               running_crc == 16'd0) ? S_DATA_EMIT : S_STATUS;
      S_DATA_EMIT: if (out_free) state_next = S_DATA_RD;
      S_STATUS: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cctl.load = 1'b0;
    cctl.init = tx_crc;
    cctl.data = tx_byte;
    if (state == S_TX_BYTE && !start_busy && req_ok && tx_pos < frm_len) cctl.load = 1'b1;
    if (state == S_IDLE && accept && in_ch.data.kind == KIND_LINE && busy_flag) begin
      cctl.load = 1'b1;
      cctl.init = running_crc;
      cctl.data = in_ch.data.data_byte;
    end
  end

  // a tick that does not run out the timeout gives no item
  always_comb begin
    ov_set = 1'b0;
    if (out_free) begin
      if (state == S_TX_EMIT || state == S_DATA_EMIT) ov_set = 1'b1;
      if (state == S_STATUS)
        ov_set = (req.kind != KIND_TICK) || (elapsed_ms > timeout_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy_flag <= 1'b0;
      ov_valid <= 1'b0;
      pending_id <= 8'd0;
      pending_function <= 8'd0;
      pending_registers <= 7'd0;
      expected_length <= 8'd0;
      received_count <= 8'd0;
      running_crc <= CrcInit;
      elapsed_ms <= 16'd0;
      timeout_limit <= 16'd0;
      start_busy <= 1'b0;
    end else begin
      state <= state_next;
      ov_valid <= ov_set || (ov_valid && !out_ch.ready);
      unique case (state)
        S_IDLE: if (accept) begin
          req <= in_ch.data;
          tx_pos <= 8'd0;
          tx_crc <= CrcInit;
          start_busy <= busy_flag;
          if (in_ch.data.kind == KIND_LINE && busy_flag)
            received_count <= received_count + 8'd1;
          if (in_ch.data.kind == KIND_TICK && busy_flag) begin
            if (elapsed_ms != 16'hFFFF) elapsed_ms <= elapsed_ms + 16'd1;
            st_code <= ST_TIMEOUT;
          end
          if (in_ch.data.kind == KIND_START)
            st_code <= busy_flag ? ST_BUSY : ST_INVALID;
        end
        S_TX_BYTE: begin
          // first pass commits the transaction
          if (!start_busy && req_ok && tx_pos == 8'd0) begin
            busy_flag <= 1'b1;
            pending_id <= req.slave_id;
            pending_function <= req.function_code;
            pending_registers <= req.register_count;
            expected_length <= exp_len;
            received_count <= 8'd0;
            running_crc <= CrcInit;
            elapsed_ms <= 16'd0;
            timeout_limit <= req.timeout_ms;
            tx_len <= frm_len;
          end
        end
        S_TX_CRC: if (crc_done && out_free) begin
          if (tx_pos < tx_len) begin
            tx_crc <= crc_q;
            ov <= '{RES_TX, tx_byte, ST_OK, 1'b0};
          end else if (tx_pos == tx_len) ov <= '{RES_TX, tx_crc[7:0], ST_OK, 1'b0};
          else ov <= '{RES_TX, tx_crc[15:8], ST_OK, 1'b1};
        end
        S_TX_EMIT: if (out_free) tx_pos <= tx_pos + 8'd1;
        S_RX_CRC: if (crc_done) running_crc <= crc_q;
        S_RX_RD1: rx0 <= rx_rd;
        S_FIN: begin
          rx1 <= rx_rd;
          busy_flag <= 1'b0;
          d_pos <= 8'd0;
          if (rx0 != pending_id || rx_rd != pending_function) st_code <= ST_MISMATCH;
          else if (running_crc != 16'd0) st_code <= ST_CRC;
          else st_code <= ST_OK;
        end
        S_DATA_RD: if (d_pos == 8'd0) n_data <= n_first;
        S_DATA_EMIT: if (out_free) begin
          ov <= '{RES_DATA, rx_rd, ST_OK, 1'b0};
          d_pos <= d_pos + 8'd1;
        end
        S_STATUS: if (out_free) begin
          ov <= '{RES_STATUS, 8'd0, st_code, 1'b1};
          if (req.kind == KIND_TICK && elapsed_ms > timeout_limit) busy_flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  `MRM_ASSERT_IMP(a_ready_idle, clk, rst, in_ch.ready, state == S_IDLE)
  `MRM_ASSERT_IMP(a_last_status, clk, rst,
                  out_ch.valid && out_ch.data.result_kind == RES_STATUS, out_ch.data.last)
  `MRM_ASSERT_IMP(a_status_zero, clk, rst,
                  out_ch.valid && out_ch.data.result_kind != RES_STATUS,
                  out_ch.data.status == ST_OK)
endmodule

// ----- tb/tb_top.sv -----
// testbench for modbus_rtu_master_transaction: directed and random transactions
// depends on mbrtu_pkg, mbrtu_if and the rtl of the block
`timescale 1ns / 1ps
module tb_top;
  import mbrtu_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int InBits = $bits(in_item_t);

  function automatic logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic bit request_ok(logic [7:0] fn, logic [6:0] cnt);
    if (fn == FN_READ_HOLD || fn == FN_READ_INPUT)
      return cnt != 0 && cnt <= MaxReadRegs && 5 + 2 * cnt <= RxFrameBytes;
    if (fn == FN_WRITE_SINGLE) return 1;
    if (fn == FN_WRITE_MULTI)
      return cnt != 0 && 2 * cnt <= PayloadDepth && 9 + 2 * cnt <= TxFrameBytes;
    return 0;
  endfunction

  class master_scoreboard;
    out_item_t pending_results[$];
    logic [7:0] payload[PayloadDepth];
    logic [7:0] rx_bytes[RxFrameBytes];
    bit waiting;
    logic [7:0] want_id, want_fn;
    logic [6:0] want_regs;
    int rx_len, rx_count;
    logic [15:0] rx_crc, ms_count, ms_limit;
    int errors, n_checked, n_status, n_data;

    function new();
      errors = 0; n_checked = 0; n_status = 0; n_data = 0;
      waiting = 0; rx_crc = CrcInit; ms_count = 0; ms_limit = 0;
      rx_count = 0; rx_len = 0;
      foreach (payload[i]) payload[i] = 0;
      foreach (rx_bytes[i]) rx_bytes[i] = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void push(logic [1:0] k, logic [7:0] v, logic [2:0] st, logic l);
      out_item_t r;
      r.result_kind = k; r.byte_value = v; r.status = st; r.last = l;
      pending_results.push_back(r);
    endfunction

    function void start_request(in_item_t it);
      logic [7:0] frame[48];
      int flen;
      logic [15:0] c;
      if (waiting) begin
        push(RES_STATUS, 0, ST_BUSY, 1);
        return;
      end
      if (!request_ok(it.function_code, it.register_count)) begin
        push(RES_STATUS, 0, ST_INVALID, 1);
        return;
      end
      frame[0] = it.slave_id;
      frame[1] = it.function_code;
      frame[2] = it.register_address[15:8];
      frame[3] = it.register_address[7:0];
      flen = 6;
      if (it.function_code == FN_WRITE_SINGLE) begin
        frame[4] = payload[0];
        frame[5] = payload[1];
        rx_len = 8;
      end else begin
        frame[4] = 0;
        frame[5] = {1'b0, it.register_count};
        rx_len = (it.function_code == FN_WRITE_MULTI) ? 8 : 5 + 2 * it.register_count;
      end
      if (it.function_code == FN_WRITE_MULTI) begin
        frame[6] = 8'(2 * it.register_count);
        for (int i = 0; i < 2 * it.register_count; i++) frame[7 + i] = payload[i];
        flen = 7 + 2 * it.register_count;
      end
      c = CrcInit;
      for (int i = 0; i < flen; i++) c = crc_fold(c, frame[i]);
      frame[flen] = c[7:0];
      frame[flen + 1] = c[15:8];
      flen += 2;
      waiting = 1;
      want_id = it.slave_id;
      want_fn = it.function_code;
      want_regs = it.register_count;
      rx_count = 0;
      rx_crc = CrcInit;
      ms_count = 0;
      ms_limit = it.timeout_ms;
      for (int i = 0; i < flen; i++) push(RES_TX, frame[i], ST_OK, i == flen - 1);
    endfunction

    function void complete();
      int n;
      waiting = 0;
      if (rx_bytes[0] != want_id || rx_bytes[1] != want_fn) begin
        push(RES_STATUS, 0, ST_MISMATCH, 1);
        return;
      end
      if (rx_crc != 0) begin
        push(RES_STATUS, 0, ST_CRC, 1);
        return;
      end
      if (want_fn == FN_READ_HOLD || want_fn == FN_READ_INPUT) begin
        n = rx_bytes[2];
        if (n > 2 * want_regs) n = 2 * want_regs;
        for (int i = 0; i < n && 3 + i < RxFrameBytes; i++)
          push(RES_DATA, rx_bytes[3 + i], ST_OK, 0);
      end
      push(RES_STATUS, 0, ST_OK, 1);
    endfunction

    function void note(in_item_t it);
      case (it.kind)
        KIND_LOAD: payload[it.payload_index] = it.data_byte;
        KIND_START: start_request(it);
        KIND_LINE: begin
          if (waiting) begin
            if (rx_count < RxFrameBytes) rx_bytes[rx_count] = it.data_byte;
            rx_count++;
            rx_crc = crc_fold(rx_crc, it.data_byte);
            if (rx_count >= rx_len || rx_count >= RxFrameBytes) complete();
          end
        end
        default: begin
          if (waiting) begin
            if (ms_count != 16'hFFFF) ms_count++;
            if (ms_count > ms_limit) begin
              waiting = 0;
              push(RES_STATUS, 0, ST_TIMEOUT, 1);
            end
          end
        end
      endcase
    endfunction

    task check(out_item_t got);
      out_item_t w;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      w = pending_results.pop_front();
      n_checked++;
      if (got.result_kind == RES_STATUS) n_status++;
      if (got.result_kind == RES_DATA) n_data++;
      if (got.result_kind !== w.result_kind)
        report($sformatf("result_kind %0d, expected %0d", got.result_kind, w.result_kind));
      if (got.byte_value !== w.byte_value)
        report($sformatf("byte_value %h, expected %h", got.byte_value, w.byte_value));
      if (got.status !== w.status)
        report($sformatf("status %0d, expected %0d", got.status, w.status));
      if (got.last !== w.last)
        report($sformatf("last %0d, expected %0d", got.last, w.last));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  int cycles = 0;
  int burst_left = 0;
  int ready_mode = 0;
  int items_sent = 0;
  bit tb_busy = 0;
  master_scoreboard sb = new();

  mbrtu_in_if in_ch ();
  mbrtu_out_if out_ch ();

  modbus_rtu_master_transaction i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // receiver stall pattern is picked at random from four modes
  always @(posedge clk) begin
    if (cycles % 64 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: out_ch.ready <= 1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= (cycles % 4 == 0);
      default: out_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check(out_ch.data);
    end
  end

  function automatic in_item_t noise_item(logic [1:0] k);
    in_item_t it;
    it = InBits'({$urandom, $urandom, $urandom});
    it.kind = k;
    return it;
  endfunction

  task automatic send(in_item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid <= 1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic load(logic [4:0] idx, logic [7:0] b);
    in_item_t it;
    it = noise_item(KIND_LOAD);
    it.payload_index = idx;
    it.data_byte = b;
    send(it);
  endtask

  task automatic line(logic [7:0] b);
    in_item_t it;
    it = noise_item(KIND_LINE);
    it.data_byte = b;
    send(it);
  endtask

  task automatic tick();
    send(noise_item(KIND_TICK));
  endtask

  task automatic start(logic [7:0] id, logic [7:0] fn, logic [15:0] addr,
                       logic [6:0] cnt, logic [15:0] tmo);
    in_item_t it;
    it = noise_item(KIND_START);
    it.slave_id = id;
    it.function_code = fn;
    it.register_address = addr;
    it.register_count = cnt;
    it.timeout_ms = tmo;
    send(it);
    if (!tb_busy && request_ok(fn, cnt)) tb_busy = 1;
  endtask

  // answer the pending request; flaw 0 good, 1 bad crc, 2 wrong id, 3 exception
  task automatic respond(logic [7:0] id, logic [7:0] fn, logic [6:0] cnt, int flaw);
    logic [7:0] frame[$];
    logic [15:0] c;
    int body;
    frame.push_back(flaw == 2 ? id ^ 8'h01 : id);
    frame.push_back(flaw == 3 ? fn | 8'h80 : fn);
    if (fn == FN_READ_HOLD || fn == FN_READ_INPUT) begin
      case ($urandom_range(0, 3))
        0: frame.push_back(8'($urandom_range(0, 255)));
        1: frame.push_back(8'($urandom_range(0, 2 * cnt)));
        default: frame.push_back(8'(2 * cnt));
      endcase
      body = 2 * cnt;
    end else begin
      // address and value or count
      body = 4;
    end
    repeat (body) frame.push_back(8'($urandom_range(0, 255)));
    c = CrcInit;
    foreach (frame[i]) c = crc_fold(c, frame[i]);
    if (flaw == 1) c ^= 16'h1 << $urandom_range(0, 15);
    frame.push_back(c[7:0]);
    frame.push_back(c[15:8]);
    foreach (frame[i]) begin
      line(frame[i]);
      if ($urandom_range(0, 15) == 0) load(5'($urandom), 8'($urandom));
    end
    tb_busy = 0;
  endtask

  task automatic transaction(logic [7:0] fn, logic [6:0] cnt);
    logic [7:0] id;
    logic [15:0] tmo;
    int pick;
    id = 8'($urandom);
    pick = $urandom_range(0, 9);
    tmo = (pick == 9) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(16, 65535));
    start(id, fn, 16'($urandom), cnt, tmo);
    if (!tb_busy) return;
    if ($urandom_range(0, 5) == 0) start(8'($urandom), FN_READ_HOLD, 16'd1, 7'd1, 16'd0);
    if (pick == 9) begin
      repeat (tmo + 1) tick();
      tb_busy = 0;
    end else begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) tick();
      respond(id, fn, cnt, pick < 6 ? 0 : pick - 5);
    end
  endtask

  initial begin
    logic [7:0] fn;
    logic [6:0] cnt;
    bit drained;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int i = 0; i < PayloadDepth; i++)
      load(5'(i), i == 0 ? 8'h00 : (i == 1 ? 8'hFF : 8'($urandom)));
    line(8'hA5);
    tick();
    start(8'h00, FN_READ_HOLD, 16'h0000, 1, 16'hFFFF);
    respond(8'h00, FN_READ_HOLD, 1, 0);
    start(8'hFF, FN_READ_INPUT, 16'hFFFF, 7'(MaxReadRegs), 16'hFFFF);
    start(8'h11, FN_WRITE_SINGLE, 16'h0001, 0, 16'd10);
    respond(8'hFF, FN_READ_INPUT, 7'(MaxReadRegs), 0);
    start(8'h22, FN_WRITE_SINGLE, 16'h1234, 7'h7F, 16'd10);
    respond(8'h22, FN_WRITE_SINGLE, 7'h7F, 1);
    start(8'h33, FN_WRITE_MULTI, 16'h00FF, 1, 16'd0);
    tick();
    tb_busy = 0;
    start(8'h44, FN_WRITE_MULTI, 16'hFF00, 11, 16'd5);
    respond(8'h44, FN_WRITE_MULTI, 11, 3);
    start(8'h55, FN_WRITE_MULTI, 16'h0, 12, 16'd5);
    start(8'h55, FN_WRITE_MULTI, 16'h0, 0, 16'd5);
    start(8'h55, FN_READ_HOLD, 16'h0, 0, 16'd5);
    start(8'h55, FN_READ_HOLD, 16'h0, 7'(MaxReadRegs + 1), 16'd5);
    start(8'h55, 8'h00, 16'h0, 1, 16'd5);
    start(8'h55, 8'hFF, 16'h0, 1, 16'd5);
    start(8'h66, FN_READ_HOLD, 16'h0, 2, 16'd5);
    respond(8'h66, FN_READ_HOLD, 2, 2);

    drained = 0;
    while (items_sent < 320) begin
      case ($urandom_range(0, 9))
        0: begin fn = 8'($urandom); cnt = 7'($urandom); end
        1: begin fn = FN_WRITE_SINGLE; cnt = 7'($urandom); end
        2, 3: begin fn = FN_WRITE_MULTI; cnt = 7'($urandom_range(1, 11)); end
        4: begin fn = FN_READ_INPUT; cnt = 7'($urandom_range(1, MaxReadRegs)); end
        default: begin fn = FN_READ_HOLD; cnt = 7'($urandom_range(1, 4)); end
      endcase
      if ($urandom_range(0, 3) == 0) load(5'($urandom), 8'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        line(8'($urandom));
        tick();
      end
      transaction(fn, cnt);
      if (!drained && items_sent > 200) begin
        drained = 1;
        in_ch.valid <= 0;
        burst_left = 0;
        wait (sb.pending_results.size() == 0);
        @(posedge clk);
      end
    end
    in_ch.valid <= 0;
    wait (sb.pending_results.size() == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d results: %0d status items and %0d response data bytes",
             sb.n_checked, sb.n_status, sb.n_data);
    $display("reads, writes, rejections, crc and id faults and timeouts were exercised");
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
